### rtl/core/rle8_slice_decoder_assert.svh
// Assertion macros for the byte run-length slice decoder.
// Each check is clocked on clk and held off while rst is high.
`ifndef RLE8_SLICE_DECODER_ASSERT_SVH
`define RLE8_SLICE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define RLE8_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RLE8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rle8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle8_pkg
// Types and constants shared by the run-length slice decoder.
// ----------------------------------------------------------------------------
package rle8_pkg;

  localparam int CFG_W      = 25;
  localparam int BYTE_W     = 8;
  localparam int RUN_W      = 7;
  localparam int LANE_W     = 3;
  localparam int LANES      = 4;
  localparam int OUT_LANES  = 4;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam logic [RUN_W-1:0]  COUNT_MASK   = 7'h7f;
  localparam logic [BYTE_W-1:0] LITERAL_FLAG = 8'h80;

  // Group size before the 32-group limit raises it: OUT_LANES clamped to 1..4.
  localparam logic [LANE_W-1:0] LANE_BASE =
    (OUT_LANES < 1) ? 3'd1 : (OUT_LANES > 4) ? 3'd4 : LANE_W'(OUT_LANES);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LITERAL = 4'b0010,
    PH_VALUE   = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_EMIT = 3'b100
  } seq_t;

endpackage

### rtl/core/rle8_slice_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle8_slice_decoder
// Byte run-length slice decoder: literal runs pass through, repeat runs are
// expanded into groups of up to four bytes, bounded by the slice size.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// s_*     | in        | s_tvalid/tready  | tdata: code_byte; tuser: slice_start
// m_*     | out       | m_tvalid/tready  | tdata: bytes 0..3, lane_count;
//         |           |                  | tlast: run_last; tuser: end, overflow
// cfg_*   | in        | cfg_we           | cfg_data: slice_bytes
//
// Every code item is accepted in S_IDLE, then evaluated through the room
// unit in S_EVAL. A repeat run that keeps any bytes then emits its output
// groups (1..32) from S_EMIT; with no room left its single item comes from
// evaluation. The output register holds a group while m_tready is low; the
// sequencer waits on it and takes no item until the register is free or
// being taken. Synchronous rst clears the slice size, state, counts and flags.
// ----------------------------------------------------------------------------
module rle8_slice_decoder #(
  parameter int COUNT_BITS = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rle8_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [7:0] code_byte
  input  logic [rle8_pkg::IN_DATA_W-1:0] s_tdata,
  // [0] slice_start
  input  logic [rle8_pkg::IN_USER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2, [31:24] out_byte3,
  // [34:32] lane_count, [39:35] zero
  output logic [rle8_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  // [0] slice_end, [1] overflow
  output logic [rle8_pkg::OUT_USER_W-1:0] m_tuser
);

  import rle8_pkg::*;

  seq_t                   state, state_next;
  phase_t                 phase, phase_next;
  logic [COUNT_BITS-1:0]  limit;
  logic [COUNT_BITS-1:0]  written, written_next;
  logic [COUNT_BITS-1:0]  room;
  logic [RUN_W-1:0]       bytes_left, bytes_left_next;
  logic [RUN_W-1:0]       kept_left, kept_left_next;
  logic [LANE_W-1:0]      group_lanes, group_lanes_next;
  logic                   ovf, ovf_next;
  logic [BYTE_W-1:0]      cur_byte;

  logic                   load;
  logic [LANE_W-1:0]      emit_lanes;
  logic                   emit_last;
  logic                   emit_end;
  logic                   emit_ovf;

  logic                   in_acc;
  logic                   out_free;
  logic [RUN_W-1:0]       kept;
  logic [LANE_W-1:0]      need;
  logic [LANE_W-1:0]      grp;
  logic [LANES*BYTE_W-1:0] lane_bytes;

  rle8_room #(.COUNT_BITS(COUNT_BITS)) u_room (
    .limit   (limit),
    .written (written),
    .room    (room)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign in_acc   = s_tvalid && s_tready;

  // Repeat run sizing: bytes that fit, and the group size that keeps the
  // run within 32 groups.
  assign kept = (COUNT_BITS'(bytes_left) < room) ? bytes_left : room[RUN_W-1:0];
  assign need = LANE_W'((8'(bytes_left) + 8'd31) >> 5);
  assign grp  = (COUNT_BITS'(kept_left) < COUNT_BITS'(group_lanes)) ?
                LANE_W'(kept_left) : group_lanes;

  always_comb begin
    state_next       = state;
    phase_next       = phase;
    written_next     = written;
    bytes_left_next  = bytes_left;
    kept_left_next   = kept_left;
    group_lanes_next = group_lanes;
    ovf_next         = ovf;
    load             = 1'b0;
    emit_lanes       = '0;
    emit_last        = 1'b1;
    emit_end         = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_IDLE;
        case (phase)
          PH_HEADER: begin
            if ((cur_byte[RUN_W-1:0] & COUNT_MASK) == '0) begin
              phase_next = PH_DONE;
              load       = 1'b1;
              emit_end   = 1'b1;
            end else begin
              bytes_left_next = cur_byte[RUN_W-1:0] & COUNT_MASK;
              phase_next      = ((cur_byte & LITERAL_FLAG) != '0) ? PH_LITERAL : PH_VALUE;
            end
          end
          PH_LITERAL: begin
            load = 1'b1;
            if (room != '0) begin
              written_next = written + COUNT_BITS'(1);
              emit_lanes   = LANE_W'(1);
            end else begin
              ovf_next = 1'b1;
            end
            bytes_left_next = bytes_left - RUN_W'(1);
            if (bytes_left == RUN_W'(1)) begin
              phase_next = PH_HEADER;
            end
          end
          PH_VALUE: begin
            if (kept != bytes_left) begin
              ovf_next = 1'b1;
            end
            written_next    = written + COUNT_BITS'(kept);
            bytes_left_next = '0;
            phase_next      = PH_HEADER;
            if (kept == '0) begin
              load = 1'b1;
            end else begin
              kept_left_next   = kept;
              group_lanes_next = (need > LANE_BASE) ? need : LANE_BASE;
              state_next       = S_EMIT;
            end
          end
          default: begin
            // done phase: drop the byte
          end
        endcase
      end
      S_EMIT: begin
        if (out_free) begin
          load           = 1'b1;
          emit_lanes     = grp;
          emit_last      = (kept_left == RUN_W'(grp));
          kept_left_next = kept_left - RUN_W'(grp);
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    emit_ovf = ovf_next;
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_bytes[i*BYTE_W +: BYTE_W] = (LANE_W'(i) < emit_lanes) ? cur_byte : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_HEADER;
      limit      <= '0;
      written    <= '0;
      bytes_left <= '0;
      kept_left  <= '0;
      ovf        <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state       <= state_next;
      kept_left   <= kept_left_next;
      group_lanes <= group_lanes_next;
      if (cfg_we) begin
        limit <= COUNT_BITS'(cfg_data);
      end
      if (in_acc && s_tuser[0]) begin
        // slice start: clear the decoder before this item is looked at
        phase      <= PH_HEADER;
        written    <= '0;
        bytes_left <= '0;
        ovf        <= 1'b0;
      end else begin
        phase      <= phase_next;
        written    <= written_next;
        bytes_left <= bytes_left_next;
        ovf        <= ovf_next;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_byte <= s_tdata;
    end
    if (load) begin
      m_tdata <= {(OUT_DATA_W - LANES*BYTE_W - LANE_W)'(0), emit_lanes, lane_bytes};
      m_tlast <= emit_last;
      m_tuser <= {emit_ovf, emit_end};
    end
  end

  `include "rle8_slice_decoder_assert.svh"

  `RLE8_ASSERT_NEXT(a_acc_eval, in_acc, state == S_EVAL, "accepted item not evaluated")
  `RLE8_ASSERT_NOW(a_emit_left, state == S_EMIT, kept_left != '0, "empty repeat group")
  `RLE8_ASSERT_NOW(a_lane_max, m_tvalid, m_tdata[34:32] <= 3'd4, "lane count above four")
  `RLE8_ASSERT_NOW(a_end_form, m_tvalid && m_tuser[0], m_tlast && (m_tdata[34:32] == 3'd0),
                   "slice end group malformed")

endmodule

### rtl/core/rle8_room.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle8_room
// Space left in the slice: limit minus bytes written, or zero once full.
// Serves both literal and repeat handling.
// ----------------------------------------------------------------------------
module rle8_room #(
  parameter int COUNT_BITS = 25
) (
  input  logic [COUNT_BITS-1:0] limit,
  input  logic [COUNT_BITS-1:0] written,
  output logic [COUNT_BITS-1:0] room
);

  assign room = (written < limit) ? (limit - written) : '0;

endmodule

### dv/rle8_slice_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle8_slice_decoder_tb
// Self-checking bench for the run-length slice decoder. Code bytes go in as
// bursts with random gaps while the output side stalls on a pattern of its
// own. A behavioural decoder predicts every output group, and each accepted
// group is compared field by field. A short table of hand-picked code bytes
// comes first, then randomly built slices under several slice sizes.
// ----------------------------------------------------------------------------
module rle8_slice_decoder_tb;
  import rle8_pkg::*;

  localparam int DOG_LIMIT   = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int RAND_ITEMS  = 230;
  localparam int MAX_GROUPS  = 32;
  localparam int N_STEPS     = 26;
  localparam logic [CFG_W-1:0] SIZE_MAX = 25'd16777216;

  // One output group as the decoder should present it.
  typedef struct packed {
    logic [31:0]       data;       // byte lanes, lane 0 lowest
    logic [LANE_W-1:0] lanes;
    logic              run_last;
    logic              slice_end;
    logic              ovf;
  } group_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_t;
  typedef enum logic {ROW_CODE, ROW_SIZE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CFG_W-1:0]   size;
    logic               start;
    logic [BYTE_W-1:0]  code;
    check_t             chk;
    group_t             typed;
  } row_t;

  localparam row_t STEPS [N_STEPS] = '{
    // empty slice straight after reset, then a byte that must be ignored
    '{ROW_CODE, '0, 1'b1, 8'h00, CHK_TYPED, '{32'h0, 3'd0, 1'b1, 1'b1, 1'b0}},
    '{ROW_CODE, '0, 1'b0, 8'h55, CHK_NONE,  '0},
    // slice size still zero: literal dropped, overflow sticks to the end
    '{ROW_CODE, '0, 1'b1, 8'h81, CHK_NONE,  '0},
    '{ROW_CODE, '0, 1'b0, 8'hA5, CHK_TYPED, '{32'h0, 3'd0, 1'b1, 1'b0, 1'b1}},
    '{ROW_CODE, '0, 1'b0, 8'h80, CHK_TYPED, '{32'h0, 3'd0, 1'b1, 1'b1, 1'b1}},
    '{ROW_SIZE, SIZE_MAX, 1'b0, 8'h00, CHK_NONE, '0},
    // longest literal run, cut short by a fresh slice start
    '{ROW_CODE, '0, 1'b1, 8'hFF, CHK_NONE,  '0},
    '{ROW_CODE, '0, 1'b0, 8'h00, CHK_TYPED, '{32'h0, 3'd1, 1'b1, 1'b0, 1'b0}},
    '{ROW_CODE, '0, 1'b0, 8'hFF, CHK_TYPED, '{32'hFF, 3'd1, 1'b1, 1'b0, 1'b0}},
    // longest repeat run: thirty-two groups
    '{ROW_CODE, '0, 1'b1, 8'h7F, CHK_NONE,  '0},
    '{ROW_CODE, '0, 1'b0, 8'hFF, CHK_MODEL, '0},
    '{ROW_CODE, '0, 1'b0, 8'h01, CHK_NONE,  '0},
    '{ROW_CODE, '0, 1'b0, 8'h00, CHK_MODEL, '0},
    '{ROW_CODE, '0, 1'b0, 8'h05, CHK_NONE,  '0},
    '{ROW_CODE, '0, 1'b0, 8'hAA, CHK_MODEL, '0},
    '{ROW_CODE, '0, 1'b0, 8'h80, CHK_TYPED, '{32'h0, 3'd0, 1'b1, 1'b1, 1'b0}},
    '{ROW_SIZE, 25'd7, 1'b0, 8'h00, CHK_NONE, '0},
    // fill the slice, then overflow inside a repeat run and with no room at all
    '{ROW_CODE, '0, 1'b1, 8'h83, CHK_NONE,  '0},
    '{ROW_CODE, '0, 1'b0, 8'h12, CHK_MODEL, '0},
    '{ROW_CODE, '0, 1'b0, 8'h34, CHK_MODEL, '0},
    '{ROW_CODE, '0, 1'b0, 8'h56, CHK_MODEL, '0},
    '{ROW_CODE, '0, 1'b0, 8'h0A, CHK_NONE,  '0},
    '{ROW_CODE, '0, 1'b0, 8'h77, CHK_MODEL, '0},
    '{ROW_CODE, '0, 1'b0, 8'h04, CHK_NONE,  '0},
    '{ROW_CODE, '0, 1'b0, 8'h99, CHK_TYPED, '{32'h0, 3'd0, 1'b1, 1'b0, 1'b1}},
    '{ROW_CODE, '0, 1'b0, 8'h00, CHK_TYPED, '{32'h0, 3'd0, 1'b1, 1'b1, 1'b1}}
  };

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  cfg_we   = 1'b0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [IN_USER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic [OUT_USER_W-1:0] m_tuser;

  // predicted decoder state
  phase_t           ph = PH_HEADER;
  logic [RUN_W-1:0] run_left = '0;
  logic [CFG_W-1:0] written = '0;
  logic             ovf_seen = 1'b0;
  logic [CFG_W-1:0] slice_limit = '0;

  group_t pending_groups [$];

  int errors = 0;
  int n_items = 0;
  int n_groups = 0;
  int n_ovf_groups = 0;
  int n_ends = 0;
  int n_sizes = 0;
  int burst_left = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int rx_cyc = 0;
  int idle_cycles = 0;

  rle8_slice_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic group_t make_group(logic [7:0] value, int lanes, bit last, bit fin);
    group_t g;
    g = '0;
    for (int i = 0; i < LANES; i++) begin
      if (i < lanes) g.data[8*i +: 8] = value;
    end
    g.lanes     = LANE_W'(lanes);
    g.run_last  = last;
    g.slice_end = fin;
    g.ovf       = ovf_seen;
    return g;
  endfunction

  // Advance the predicted state by one code byte; queue its groups if asked.
  task automatic decode_byte(input bit start, input logic [7:0] code, input bit keep);
    logic [RUN_W-1:0] cnt;
    logic [CFG_W-1:0] room;
    int kept;
    int lanes;
    int need;
    int g_size;
    int n;
    if (start) begin
      ph       = PH_HEADER;
      run_left = '0;
      written  = '0;
      ovf_seen = 1'b0;
    end
    room = (written < slice_limit) ? slice_limit - written : '0;
    case (ph)
      PH_HEADER: begin
        cnt = code[RUN_W-1:0] & COUNT_MASK;
        if (cnt == 0) begin
          ph = PH_DONE;
          if (keep) pending_groups.push_back(make_group(8'h00, 0, 1'b1, 1'b1));
        end else begin
          run_left = cnt;
          ph = ((code & LITERAL_FLAG) != 0) ? PH_LITERAL : PH_VALUE;
        end
      end
      PH_LITERAL: begin
        lanes = 0;
        if (room != 0) begin
          written = written + 1'b1;
          lanes = 1;
        end else begin
          ovf_seen = 1'b1;
        end
        run_left = run_left - 1'b1;
        if (run_left == 0) ph = PH_HEADER;
        if (keep) pending_groups.push_back(make_group(code, lanes, 1'b1, 1'b0));
      end
      PH_VALUE: begin
        kept  = (run_left < room) ? int'(run_left) : int'(room);
        lanes = OUT_LANES;
        if (lanes < 1) lanes = 1;
        if (lanes > LANES) lanes = LANES;
        need = (int'(run_left) + MAX_GROUPS - 1) / MAX_GROUPS;
        if (lanes < need) lanes = need;
        if (kept < int'(run_left)) ovf_seen = 1'b1;
        written  = written + CFG_W'(kept);
        run_left = '0;
        ph       = PH_HEADER;
        if (kept == 0) begin
          if (keep) pending_groups.push_back(make_group(code, 0, 1'b1, 1'b0));
        end else begin
          n = 0;
          while (kept > 0 && n < MAX_GROUPS) begin
            g_size = (kept < lanes) ? kept : lanes;
            kept -= g_size;
            if (keep) pending_groups.push_back(make_group(code, g_size, kept == 0, 1'b0));
            n++;
          end
        end
      end
      default: ;  // done: drop everything until the next slice start
    endcase
  endtask

  // Offer one code byte, in bursts with random gaps, and predict on acceptance.
  task automatic send_code(input bit start, input logic [7:0] code, input check_t chk,
                           input group_t typed);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tuser  <= start;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    if (start || ph != PH_DONE) n_items++;
    decode_byte(start, code, chk == CHK_MODEL);
    if (chk == CHK_TYPED) pending_groups.push_back(typed);
  endtask

  // Write the slice size once the decoder has drained.
  task automatic set_size(input logic [CFG_W-1:0] size);
    s_tvalid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_limit = size;
    n_sizes++;
    burst_left = 0;
  endtask

  // One slice: runs of literals and repeats, closed by an end header.
  // Some slices break off mid-run and are followed by noise.
  task automatic random_slice();
    int runs;
    int cnt;
    int k;
    bit lit;
    bit broken;
    bit first;
    broken = ($urandom_range(0, 4) == 0);
    runs   = $urandom_range(1, 5);
    first  = 1'b1;
    for (int r = 0; r < runs; r++) begin
      lit = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0:       cnt = 1;
        1:       cnt = 127;
        2:       cnt = lit ? $urandom_range(1, 40) : $urandom_range(1, 127);
        default: cnt = lit ? $urandom_range(1, 8) : $urandom_range(1, 127);
      endcase
      send_code(first, {lit, RUN_W'(cnt)}, CHK_MODEL, '0);
      first = 1'b0;
      k = (broken && r == runs - 1) ? $urandom_range(0, cnt - 1) : cnt;
      if (lit) begin
        repeat (k) send_code(1'b0, 8'($urandom), CHK_MODEL, '0);
      end else if (k == cnt) begin
        send_code(1'b0, 8'($urandom), CHK_MODEL, '0);
      end
    end
    if (!broken) begin
      send_code(1'b0, $urandom_range(0, 1) ? LITERAL_FLAG : 8'h00, CHK_MODEL, '0);
      repeat ($urandom_range(0, 2)) send_code(1'b0, 8'($urandom), CHK_MODEL, '0);
    end else begin
      repeat ($urandom_range(0, 4))
        send_code($urandom_range(0, 7) == 0, 8'($urandom), CHK_MODEL, '0);
    end
  endtask

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Output side: stall pattern changes with bits 8:7 of the cycle counter; long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready     <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
      rx_cyc       <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (holds_served != holds_asked) begin
        holds_served <= holds_asked;
        hold_left    <= HOLD_CYCLES;
        m_tready     <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        case (rx_cyc[8:7])
          2'd0:    m_tready <= 1'b1;
          2'd1:    m_tready <= 1'($urandom_range(0, 1));
          2'd2:    m_tready <= (rx_cyc % 3) != 0;
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare every accepted group with the oldest prediction.
  always @(posedge clk) begin
    group_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_groups.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: unexpected group, expected none, actual tdata %0h tlast %0b tuser %0b",
                   $time, m_tdata, m_tlast, m_tuser);
      end else begin
        want = pending_groups.pop_front();
        n_groups++;
        if (want.ovf) n_ovf_groups++;
        if (want.slice_end) n_ends++;
        for (int i = 0; i < LANES; i++) begin
          if (m_tdata[8*i +: 8] !== want.data[8*i +: 8])
            report($sformatf("out_byte%0d", i), want.data[8*i +: 8], m_tdata[8*i +: 8]);
        end
        if (m_tdata[34:32] !== want.lanes) report("lane_count", want.lanes, m_tdata[34:32]);
        if (m_tdata[39:35] !== 5'd0) report("tdata padding", 0, m_tdata[39:35]);
        if (m_tlast !== want.run_last) report("run_last", want.run_last, m_tlast);
        if (m_tuser[0] !== want.slice_end) report("slice_end", want.slice_end, m_tuser[0]);
        if (m_tuser[1] !== want.ovf) report("overflow", want.ovf, m_tuser[1]);
      end
    end
  end

  // Stop a hung run: nothing moving on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= DOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", DOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int dir_items;
    bit pressed;
    logic [CFG_W-1:0] size;
    pressed = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (STEPS[i]) begin
      if (STEPS[i].kind == ROW_SIZE) set_size(STEPS[i].size);
      else send_code(STEPS[i].start, STEPS[i].code, STEPS[i].chk, STEPS[i].typed);
    end
    dir_items = n_items;

    while (n_items < dir_items + RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0:       size = '0;
          1:       size = 25'd1;
          2:       size = CFG_W'($urandom_range(2, 48));
          3:       size = CFG_W'($urandom_range(49, 600));
          4:       size = SIZE_MAX;
          default: size = CFG_W'($urandom_range(0, 16777216));
        endcase
        set_size(size);
      end
      // hold the output off while input keeps coming, to back the block up
      if (!pressed && n_items >= dir_items + RAND_ITEMS / 2) begin
        holds_asked <= holds_asked + 1;
        pressed = 1'b1;
      end
      random_slice();
    end

    s_tvalid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d code items and %0d output groups over %0d slice sizes;",
             n_items, n_groups, n_sizes);
    $display("%0d groups carried overflow and %0d closed a slice.", n_ovf_groups, n_ends);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rle8_pkg.sv
rtl/core/rle8_room.sv
rtl/core/rle8_slice_decoder.sv
dv/rle8_slice_decoder_tb.sv
